// ----- design/udf_pkg.sv -----
`default_nettype none

package udf_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] NODE_ADDR  = 8'h00;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    // command codes
    localparam logic [1:0] CMD_READ_REQ  = 2'd0;
    localparam logic [1:0] CMD_WRITE_REQ = 2'd1;
    localparam logic [1:0] CMD_RX_BYTE   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_TX         = 2'd0;
    localparam logic [1:0] KIND_READ_DONE  = 2'd1;
    localparam logic [1:0] KIND_WRITE_DONE = 2'd2;

    // datagram and receive lengths
    localparam logic [2:0] READ_TX_LAST  = 3'd3;
    localparam logic [2:0] WRITE_TX_LAST = 3'd7;
    localparam logic [3:0] READ_RX_LAST  = 4'd11;
    localparam logic [3:0] WRITE_RX_LAST = 4'd7;
    localparam logic [3:0] REPLY_CRC_LO  = 4'd4;
    localparam logic [3:0] REPLY_CRC_HI  = 4'd10;
    localparam logic [3:0] REPLY_DATA_LO = 4'd7;

    // pending operation codes
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_READ  = 2'd1;
    localparam logic [1:0] PEND_WRITE = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  reg_addr;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [31:0] read_data;
        logic        ok;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_REQ_READ,
        JOB_REQ_WRITE,
        JOB_RES_READ,
        JOB_RES_WRITE
    } job_kind_t;

    // data carries write value for requests, reply value for read results
    typedef struct packed {
        job_kind_t   kind;
        logic [6:0]  reg_addr;
        logic [31:0] data;
        logic        ok;
    } job_t;

    // CRC8, poly 0x07, data fed LSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ b[i]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/udf_front.sv -----
`default_nettype none

module udf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire udf_pkg::in_item_t in_item,
    input  wire logic              q_full,
    output logic                   q_push,
    output udf_pkg::job_t          q_job
);
    import udf_pkg::*;

    logic [1:0]  pending_op_reg, pending_op_next;
    logic [3:0]  rx_count_reg, rx_count_next;
    logic [7:0]  rx_crc_reg, rx_crc_next;
    logic        sync_good_reg, sync_good_next;
    logic [31:0] data_shift_reg, data_shift_next;
    logic        accept;
    logic        sync_now;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sync_now = (rx_count_reg == 4'd0) ? (in_item.rx_byte == SYNC_BYTE) : sync_good_reg;

    always_comb
    begin
        pending_op_next = pending_op_reg;
        rx_count_next   = rx_count_reg;
        rx_crc_next     = rx_crc_reg;
        sync_good_next  = sync_good_reg;
        data_shift_next = data_shift_reg;
        q_push          = 1'b0;
        q_job.kind      = JOB_REQ_READ;
        q_job.reg_addr  = in_item.reg_addr;
        q_job.data      = in_item.write_data;
        q_job.ok        = 1'b0;
        if (accept) begin
            if (in_item.command == CMD_READ_REQ || in_item.command == CMD_WRITE_REQ) begin
                // new request drops anything pending
                q_push          = 1'b1;
                q_job.kind      = (in_item.command == CMD_READ_REQ) ? JOB_REQ_READ
                                                                    : JOB_REQ_WRITE;
                pending_op_next = (in_item.command == CMD_READ_REQ) ? PEND_READ : PEND_WRITE;
                rx_count_next   = 4'd0;
                rx_crc_next     = 8'h00;
                sync_good_next  = 1'b0;
                data_shift_next = 32'h0;
            end else if (in_item.command == CMD_RX_BYTE && pending_op_reg != PEND_NONE) begin
                sync_good_next = sync_now;
                rx_count_next  = rx_count_reg + 4'd1;
                if (pending_op_reg == PEND_READ) begin
                    if (rx_count_reg >= REPLY_CRC_LO && rx_count_reg <= REPLY_CRC_HI) begin
                        rx_crc_next = crc8_feed(rx_crc_reg, in_item.rx_byte);
                    end
                    if (rx_count_reg >= REPLY_DATA_LO && rx_count_reg <= REPLY_CRC_HI) begin
                        data_shift_next = {data_shift_reg[23:0], in_item.rx_byte};
                    end
                    if (rx_count_reg == READ_RX_LAST) begin
                        q_push          = 1'b1;
                        q_job.kind      = JOB_RES_READ;
                        q_job.data      = data_shift_reg;
                        q_job.ok        = sync_now && (rx_crc_reg == in_item.rx_byte);
                        pending_op_next = PEND_NONE;
                        rx_count_next   = 4'd0;
                    end
                end else if (rx_count_reg == WRITE_RX_LAST) begin
                    q_push          = 1'b1;
                    q_job.kind      = JOB_RES_WRITE;
                    q_job.ok        = sync_now;
                    pending_op_next = PEND_NONE;
                    rx_count_next   = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_op_reg <= PEND_NONE;
            rx_count_reg   <= 4'd0;
            rx_crc_reg     <= 8'h00;
            sync_good_reg  <= 1'b0;
            data_shift_reg <= 32'h0;
        end else begin
            pending_op_reg <= pending_op_next;
            rx_count_reg   <= rx_count_next;
            rx_crc_reg     <= rx_crc_next;
            sync_good_reg  <= sync_good_next;
            data_shift_reg <= data_shift_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/udf_queue.sv -----
`default_nettype none

module udf_queue #(
    parameter int Depth = udf_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire udf_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output udf_pkg::job_t      head
);
    import udf_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    job_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/udf_back.sv -----
`default_nettype none

module udf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire udf_pkg::job_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output udf_pkg::out_item_t out_item
);
    import udf_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic [7:0] crc_reg, crc_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       load;
    logic       is_req;
    logic       is_last;
    logic [2:0] last_idx;
    logic [7:0] byte_now;

    assign load     = !q_empty && (!out_valid_reg || out_ready);
    assign is_req   = (q_head.kind == JOB_REQ_READ) || (q_head.kind == JOB_REQ_WRITE);
    assign last_idx = (q_head.kind == JOB_REQ_READ) ? READ_TX_LAST : WRITE_TX_LAST;
    assign is_last  = !is_req || (idx_reg == last_idx);

    always_comb
    begin
        case (idx_reg)
            3'd0:    byte_now = SYNC_BYTE;
            3'd1:    byte_now = NODE_ADDR;
            3'd2:    byte_now = {(q_head.kind == JOB_REQ_WRITE), q_head.reg_addr};
            3'd3:    byte_now = q_head.data[31:24];
            3'd4:    byte_now = q_head.data[23:16];
            3'd5:    byte_now = q_head.data[15:8];
            3'd6:    byte_now = q_head.data[7:0];
            default: byte_now = 8'h00;
        endcase
        if (is_last) begin
            byte_now = crc_reg;
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        if (load) begin
            out_valid_next = 1'b1;
            out_next       = '0;
            unique case (q_head.kind)
                JOB_REQ_READ, JOB_REQ_WRITE:
                begin
                    out_next.kind    = KIND_TX;
                    out_next.tx_byte = byte_now;
                    out_next.tx_last = is_last;
                end
                JOB_RES_READ:
                begin
                    out_next.kind      = KIND_READ_DONE;
                    out_next.read_data = q_head.data;
                    out_next.ok        = q_head.ok;
                end
                JOB_RES_WRITE:
                begin
                    out_next.kind = KIND_WRITE_DONE;
                    out_next.ok   = q_head.ok;
                end
            endcase
            if (is_last) begin
                q_pop    = 1'b1;
                idx_next = 3'd0;
                crc_next = 8'h00;
            end else begin
                idx_next = idx_reg + 3'd1;
                crc_next = crc8_feed(crc_reg, byte_now);
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 3'd0;
            crc_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ----- design/uart_register_datagram_framer_unit.sv -----
// Host-side framer for a single-wire UART register link. Each input item is
// a read request, a write request or one byte received from the wire. A read
// request yields four transmit items (sync 0x05, node 0, register, CRC8) and a
// write request eight (sync, node, register|0x80, data MSB first, CRC8); the
// CRC8 uses polynomial 0x07, init 0, bits fed LSB first. After a read, twelve
// received bytes (echo plus reply) give one read-done item with the register
// value and ok set when the sync byte and reply CRC were good; after a write,
// eight echo bytes give one write-done item. Bytes with nothing pending and
// command 3 give nothing; a new request abandons any pending exchange. The
// front end takes one item per cycle while the job queue has room, so input
// is accepted even while the output is stalled. The back end emits one result
// per cycle while out_ready does not hold it, one datagram byte per result for
// a request; a job leaves the queue when its last result is loaded. An accepted
// item is registered in the job queue and then in the output register.
`default_nettype none

module uart_register_datagram_framer_unit #(
    parameter int QueueDepth = udf_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire udf_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output udf_pkg::out_item_t      out_item
);
    import udf_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t q_job;
    job_t q_head;

    // front: classifies items, tracks the receive exchange
    udf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    udf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // back: expands jobs into datagram bytes or completion items
    udf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("job popped from empty queue");

    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.kind == KIND_TX) |-> (!out_item.ok && out_item.read_data == '0))
        else $error("transmit item carries completion fields");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.kind != KIND_TX) |-> (out_item.tx_byte == '0 && !out_item.tx_last))
        else $error("completion item carries transmit fields");

endmodule

`default_nettype wire
